FILE: rtl/rpbg_pkg.sv
`default_nettype none
package rpbg_pkg;

   localparam int MAX_DIM_DEF = 1024;

   localparam int CFG_IDX_W = 3;
   localparam int CFG_DATA_W = 11;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_EDGE_INSET   = 3'd2,
      REG_CORNER_RAD   = 3'd3,
      REG_TRANSP_PCT   = 3'd4,
      REG_BG_RED       = 3'd5,
      REG_BG_GREEN     = 3'd6,
      REG_BG_BLUE      = 3'd7
   } reg_idx_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ALPHA, S_BOX, S_SQX, S_SQY, S_SQR, S_DIV, S_GRAD,
      S_CMUL, S_CSCL, S_CPRE, S_WHITE, S_BLEND, S_SHADE, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_MAIN, MODE_RING, MODE_SHADOW
   } mode_type;

   // reciprocal of 100 in Q19, exact for numerators below 43600
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int RECIP_SHIFT = 19;
   localparam logic [6:0] LIGHT_TOP = 7'd108;
   localparam logic [5:0] RING_WHITE = 6'd42;
   localparam logic [6:0] PCT_FULL = 7'd100;

   // x / 255 for x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return s[15:8];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rounded_panel_background_gen_top.sv
// Path per pixel, accept to result beat: a pixel outside the frame, or outside the shape
//   with zero fill alpha, goes to the result; an inside pixel runs the divider, colour
//   channels and ring test; a shadow pixel tests rectangles of growing spread.
// Throughput: one pixel at a time, set by the shared multiplier and the 5-step restoring
//   divider; a stalled result beat holds the sequencer until it is taken.
// Reset: synchronous, active high; registers return to 256, 96, 8, 22, 0, 0, 0, 0.
`default_nettype none
module rounded_panel_background_gen_top #(
   parameter int MAX_DIM = rpbg_pkg::MAX_DIM_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [9:0]                      req_pixel_x,
   input  wire logic [9:0]                      req_pixel_y,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [31:0]                          rsp_pixel_argb,
   input  wire logic                            csr_we,
   input  wire logic [rpbg_pkg::CFG_IDX_W-1:0]  csr_index,
   input  wire logic [rpbg_pkg::CFG_DATA_W-1:0] csr_wdata
);
   import rpbg_pkg::*;

   localparam logic [12:0] MAX_W = 13'(MAX_DIM);

   // configuration
   logic [10:0] fw_ff, fh_ff;
   logic [5:0]  inset_ff;
   logic [7:0]  crad_ff;
   logic [6:0]  tpct_ff;
   logic [7:0]  bgr_ff, bgg_ff, bgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 11'd256;
         fh_ff <= 11'd96;
         inset_ff <= 6'd8;
         crad_ff <= 8'd22;
         tpct_ff <= 7'd0;
         bgr_ff <= 8'd0;
         bgg_ff <= 8'd0;
         bgb_ff <= 8'd0;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_FRAME_WIDTH:  fw_ff <= csr_wdata;
            REG_FRAME_HEIGHT: fh_ff <= csr_wdata;
            REG_EDGE_INSET:   inset_ff <= csr_wdata[5:0];
            REG_CORNER_RAD:   crad_ff <= csr_wdata[7:0];
            REG_TRANSP_PCT:   tpct_ff <= csr_wdata[6:0];
            REG_BG_RED:       bgr_ff <= csr_wdata[7:0];
            REG_BG_GREEN:     bgg_ff <= csr_wdata[7:0];
            REG_BG_BLUE:      bgb_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   logic [9:0]  x_ff, x_in, y_ff, y_in;
   logic [7:0]  alpha_ff, alpha_in;
   logic [6:0]  light_ff, light_in;
   logic [5:0]  spread_ff, spread_in;
   logic [1:0]  chan_ff, chan_in;
   logic [31:0] px_ff, px_in;
   logic [17:0] sq_ff, sq_in;
   logic [14:0] tmp_ff, tmp_in;
   logic [7:0]  wa_ff, wa_in;
   logic [14:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [4:0]  quo_ff, quo_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // frame geometry
   logic [12:0] w_u, h_u;
   logic signed [13:0] w_s, h_s, x_s, y_s, in_s;
   logic signed [13:0] d_s, l_s, t_s, r_s, b_s, rad_s, dxw, dyw;
   logic [8:0]  dx, dy, rad9;
   logic        in_frame, inbox, corner;
   logic signed [13:0] content_s, gdiv_s;
   logic [6:0]  tsat;
   logic [6:0]  tsub;

   assign w_u = ({2'b0, fw_ff} > MAX_W) ? MAX_W : {2'b0, fw_ff};
   assign h_u = ({2'b0, fh_ff} > MAX_W) ? MAX_W : {2'b0, fh_ff};
   assign w_s = signed'({1'b0, w_u});
   assign h_s = signed'({1'b0, h_u});
   assign x_s = signed'({4'b0, x_ff});
   assign y_s = signed'({4'b0, y_ff});
   assign in_s = signed'({8'b0, inset_ff});
   assign in_frame = (x_s < w_s) && (y_s < h_s);

   // rectangle offset: ring is one pixel in, shadow rectangles grow by spread
   always_comb begin
      unique case (mode_ff)
         MODE_RING:   d_s = 14'sd1;
         MODE_SHADOW: d_s = -signed'({8'b0, spread_ff});
         default:     d_s = 14'sd0;
      endcase
   end

   assign l_s = in_s + d_s;
   assign t_s = in_s + d_s;
   assign r_s = w_s - in_s - d_s;
   assign b_s = h_s - in_s - d_s;
   assign rad_s = signed'({6'b0, crad_ff}) - d_s;
   assign rad9 = rad_s[8:0];
   assign inbox = (x_s >= l_s) && (x_s < r_s) && (y_s >= t_s) && (y_s < b_s);

   always_comb begin
      if (x_s < l_s + rad_s) dxw = l_s + rad_s - x_s;
      else if (x_s >= r_s - rad_s) dxw = x_s - (r_s - rad_s - 14'sd1);
      else dxw = 14'sd0;
      if (y_s < t_s + rad_s) dyw = t_s + rad_s - y_s;
      else if (y_s >= b_s - rad_s) dyw = y_s - (b_s - rad_s - 14'sd1);
      else dyw = 14'sd0;
   end

   // inside the box the corner distances never exceed the radius
   assign dx = dxw[8:0];
   assign dy = dyw[8:0];
   assign corner = (dx != 9'd0) && (dy != 9'd0);

   assign content_s = h_s - (in_s <<< 1);
   assign gdiv_s = (content_s > 14'sd1) ? content_s - 14'sd1 : 14'sd1;
   assign tsat = (tpct_ff > PCT_FULL) ? PCT_FULL : tpct_ff;
   assign tsub = PCT_FULL - tsat;

   // shared multiplier
   logic [14:0] mul_a;
   logic [12:0] mul_b;
   logic [27:0] mul_p;
   logic [7:0]  bg_sel, px_byte;

   always_comb begin
      case (chan_ff)
         2'd1:    bg_sel = bgr_ff;
         2'd2:    bg_sel = bgg_ff;
         default: bg_sel = bgb_ff;
      endcase
      case (chan_ff)
         2'd0:    px_byte = px_ff[31:24];
         2'd1:    px_byte = px_ff[23:16];
         2'd2:    px_byte = px_ff[15:8];
         default: px_byte = px_ff[7:0];
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ALPHA: begin
            mul_a = {tsub, 8'd0} - {8'd0, tsub};
            mul_b = RECIP_100;
         end
         S_SQX: begin mul_a = {6'd0, dx}; mul_b = {4'd0, dx}; end
         S_SQY: begin mul_a = {6'd0, dy}; mul_b = {4'd0, dy}; end
         S_SQR: begin mul_a = {6'd0, rad9}; mul_b = {4'd0, rad9}; end
         S_CMUL: begin mul_a = {7'd0, bg_sel}; mul_b = {6'd0, light_ff}; end
         S_CSCL: begin mul_a = tmp_ff; mul_b = RECIP_100; end
         S_CPRE: begin mul_a = tmp_ff; mul_b = {5'd0, alpha_ff}; end
         S_WHITE: begin mul_a = {7'd0, alpha_ff}; mul_b = {7'd0, RING_WHITE}; end
         S_BLEND: begin mul_a = {7'd0, px_byte}; mul_b = {5'd0, 8'd255 - wa_ff}; end
         default: ;
      endcase
   end

   assign mul_p = 28'(mul_a) * 28'(mul_b);

   // corner test outcome
   logic test_done, test_hit;
   always_comb begin
      test_done = 1'b0;
      test_hit = 1'b0;
      if (state_ff == S_BOX) begin
         test_done = !inbox || !corner;
         test_hit = inbox;
      end else if (state_ff == S_SQR) begin
         test_done = 1'b1;
         test_hit = !(sq_ff > mul_p[17:0]);
      end
   end

   logic [15:0] dtrial;
   assign dtrial = {1'b0, rem_ff} - {1'b0, dsh_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_ALPHA;
         S_ALPHA: state_in = in_frame ? S_BOX : S_DONE;
         S_BOX, S_SQR: begin
            if (!test_done) state_in = S_SQX;
            else begin
               unique case (mode_ff)
                  MODE_MAIN: begin
                     if (test_hit) state_in = S_DIV;
                     else if (mul_p[26:19] == 8'd0 && alpha_ff == 8'd0) state_in = S_DONE;
                     else if (inset_ff == 6'd0) state_in = S_DONE;
                     else state_in = S_BOX;
                  end
                  MODE_RING: state_in = test_hit ? S_DONE : S_WHITE;
                  default: begin
                     if (test_hit) state_in = S_DIV;
                     else if (spread_ff == inset_ff) state_in = S_DONE;
                     else state_in = S_BOX;
                  end
               endcase
            end
         end
         S_SQX:   state_in = S_SQY;
         S_SQY:   state_in = S_SQR;
         S_DIV:   if (dcnt_ff == 3'd4) state_in = (mode_ff == MODE_MAIN) ? S_GRAD : S_SHADE;
         S_GRAD:  state_in = S_CMUL;
         S_CMUL:  state_in = S_CSCL;
         S_CSCL:  state_in = S_CPRE;
         S_CPRE:  state_in = (chan_ff == 2'd3) ? S_BOX : S_CMUL;
         S_WHITE: state_in = S_BLEND;
         S_BLEND: if (chan_ff == 2'd3) state_in = S_DONE;
         S_SHADE: state_in = S_DONE;
         S_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   logic [8:0] scaled;
   always_comb begin
      mode_in = mode_ff;
      x_in = x_ff;
      y_in = y_ff;
      alpha_in = alpha_ff;
      light_in = light_ff;
      spread_in = spread_ff;
      chan_in = chan_ff;
      px_in = px_ff;
      sq_in = sq_ff;
      tmp_in = tmp_ff;
      wa_in = wa_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      scaled = mul_p[27:19];
      case (state_ff)
         S_IDLE: if (req_valid) begin
            x_in = req_pixel_x;
            y_in = req_pixel_y;
            px_in = '0;
            mode_in = MODE_MAIN;
         end
         S_ALPHA: alpha_in = mul_p[26:19];
         S_BOX, S_SQR: if (test_done) begin
            unique case (mode_ff)
               MODE_MAIN: begin
                  if (test_hit) begin
                     rem_in = 15'((y_s - in_s) <<< 4);
                     dsh_in = 15'(gdiv_s <<< 4);
                     dcnt_in = 3'd0;
                  end else begin
                     mode_in = MODE_SHADOW;
                     spread_in = 6'd1;
                  end
               end
               MODE_RING: ;
               default: begin
                  if (test_hit) begin
                     rem_in = 15'({9'd0, inset_ff - spread_ff + 6'd1} * 15'd24);
                     dsh_in = 15'({8'd0, {1'b0, inset_ff} + 7'd1} << 4);
                     dcnt_in = 3'd0;
                  end else spread_in = spread_ff + 6'd1;
               end
            endcase
         end
         S_SQX: sq_in = mul_p[17:0];
         S_SQY: sq_in = sq_ff + mul_p[17:0];
         S_DIV: begin
            quo_in = {quo_ff[3:0], !dtrial[15]};
            if (!dtrial[15]) rem_in = dtrial[14:0];
            dsh_in = dsh_ff >> 1;
            dcnt_in = dcnt_ff + 3'd1;
         end
         S_GRAD: begin
            light_in = LIGHT_TOP - {2'd0, quo_ff};
            chan_in = 2'd1;
         end
         S_CMUL: tmp_in = mul_p[14:0];
         S_CSCL: tmp_in = {7'd0, (scaled > 9'd255) ? 8'd255 : scaled[7:0]};
         S_CPRE: begin
            case (chan_ff)
               2'd1:    px_in[23:16] = div255(mul_p[15:0]);
               2'd2:    px_in[15:8] = div255(mul_p[15:0]);
               default: px_in[7:0] = div255(mul_p[15:0]);
            endcase
            if (chan_ff == 2'd3) begin
               px_in[31:24] = alpha_ff;
               mode_in = MODE_RING;
            end
            chan_in = chan_ff + 2'd1;
         end
         S_WHITE: begin
            wa_in = div255(mul_p[15:0]);
            chan_in = 2'd0;
         end
         S_BLEND: begin
            case (chan_ff)
               2'd0:    px_in[31:24] = wa_ff + div255(mul_p[15:0]);
               2'd1:    px_in[23:16] = wa_ff + div255(mul_p[15:0]);
               2'd2:    px_in[15:8] = wa_ff + div255(mul_p[15:0]);
               default: px_in[7:0] = wa_ff + div255(mul_p[15:0]);
            endcase
            chan_in = chan_ff + 2'd1;
         end
         S_SHADE: px_in = {3'd0, quo_ff, 24'd0};
         S_DONE: if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = px_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      x_ff <= x_in;
      y_ff <= y_in;
      alpha_ff <= alpha_in;
      light_ff <= light_in;
      spread_ff <= spread_in;
      chan_ff <= chan_in;
      px_ff <= px_in;
      sq_ff <= sq_in;
      tmp_ff <= tmp_in;
      wa_ff <= wa_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_argb = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/rpbg_chk.sv
`default_nettype none
module rpbg_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_pixel_argb
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_argb))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // one pixel in work at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting a beat");

   // premultiplied: no channel exceeds alpha
   a_premul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_argb[23:16] <= rsp_pixel_argb[31:24] &&
                    rsp_pixel_argb[15:8] <= rsp_pixel_argb[31:24] &&
                    rsp_pixel_argb[7:0] <= rsp_pixel_argb[31:24])
      else $error("channel above alpha");

endmodule

bind rounded_panel_background_gen_top rpbg_chk u_rpbg_chk (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_pixel_argb(rsp_pixel_argb)
);
`default_nettype wire
